/* rtl/core/ezr_pkg.sv */
// Shared types, constants and arithmetic helpers for the ZYX Euler to matrix block.
`default_nettype none
package ezr_pkg;

  localparam int ANGLE_BITS      = 16;
  localparam int FRAC_BITS       = 14;
  localparam int TRIG_ITERATIONS = 16;
  localparam int FIELD_W         = 16;
  localparam int CW              = 32;
  localparam int TRIG_SHIFT      = 30 - FRAC_BITS;

  localparam logic signed [CW-1:0]      CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [FIELD_W-1:0] ONE         = FIELD_W'(1 << FRAC_BITS);

  typedef struct packed {
    logic signed [FIELD_W-1:0] yaw_angle;
    logic signed [FIELD_W-1:0] pitch_angle;
    logic signed [FIELD_W-1:0] roll_angle;
  } angles_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] m00;
    logic signed [FIELD_W-1:0] m01;
    logic signed [FIELD_W-1:0] m02;
    logic signed [FIELD_W-1:0] m10;
    logic signed [FIELD_W-1:0] m11;
    logic signed [FIELD_W-1:0] m12;
    logic signed [FIELD_W-1:0] m20;
    logic signed [FIELD_W-1:0] m21;
    logic signed [FIELD_W-1:0] m22;
  } matrix_t;

  // one rotator lane: vector, residual angle and folded-off quadrant
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [1:0]           quad;
  } ezr_lane_t;

  // lane 0 yaw, 1 pitch, 2 roll
  typedef ezr_lane_t [2:0] ezr_lanes_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] s;
    logic signed [FIELD_W-1:0] c;
  } ezr_trig_t;

  // atan(2^-k) in turn units of 2^-32
  function automatic logic signed [CW-1:0] atan_turn(input logic [4:0] k);
    logic signed [CW-1:0] r;
    unique case (k)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // rounded fixed-point product, operands within +-1.0
  function automatic logic signed [FIELD_W-1:0] mul_round(
      input logic signed [FIELD_W-1:0] a, input logic signed [FIELD_W-1:0] b);
    logic signed [2*FIELD_W-1:0] p;
    p = (2*FIELD_W)'(a) * (2*FIELD_W)'(b) + (2*FIELD_W)'(1 << (FRAC_BITS - 1));
    return FIELD_W'(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [FIELD_W-1:0] clamp17(input logic signed [FIELD_W:0] v);
    logic signed [FIELD_W-1:0] r;
    if (v > (FIELD_W+1)'(ONE)) begin
      r = ONE;
    end else if (v < -((FIELD_W+1)'(ONE))) begin
      r = -ONE;
    end else begin
      r = FIELD_W'(v);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/ezr_cordic_cell.sv */
// One rotation-mode CORDIC iteration for the three angle lanes, with its pipeline slot.
`default_nettype none
module ezr_cordic_cell import ezr_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       prev_valid,
  input  wire ezr_lanes_t prev_lanes,
  input  wire logic       next_load,
  output logic            load,
  output logic            valid,
  output ezr_lanes_t      lanes
);

  localparam logic [4:0] K = 5'(IDX % 32);

  ezr_lanes_t lanes_next;

  // slot takes new data when empty or when its content moves on
  assign load = !valid || next_load;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      lanes_next[l].quad = prev_lanes[l].quad;
      if (!prev_lanes[l].z[CW-1]) begin
        lanes_next[l].x = prev_lanes[l].x - (prev_lanes[l].y >>> K);
        lanes_next[l].y = prev_lanes[l].y + (prev_lanes[l].x >>> K);
        lanes_next[l].z = prev_lanes[l].z - atan_turn(K);
      end else begin
        lanes_next[l].x = prev_lanes[l].x + (prev_lanes[l].y >>> K);
        lanes_next[l].y = prev_lanes[l].y - (prev_lanes[l].x >>> K);
        lanes_next[l].z = prev_lanes[l].z + atan_turn(K);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lanes <= lanes_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/ezr_matrix.sv */
// Quadrant fold, trig rounding, products and sums of the matrix in a three-stage pipeline.
`default_nettype none
module ezr_matrix import ezr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       prev_valid,
  input  wire ezr_lanes_t prev_lanes,
  input  wire logic       stall,
  output logic            load,
  output logic            valid,
  output matrix_t         matrix
);

  // stage T: trig values, stage P: two-factor products, stage M: entries
  logic         t_valid, p_valid;
  logic         t_load, p_load, m_load;
  ezr_trig_t    trig_next [3];
  ezr_trig_t    trig [3];
  matrix_t      matrix_next;

  logic signed [FIELD_W-1:0] p_cpcy, p_cpsy, p_crsy, p_cysp, p_spsr, p_crcy;
  logic signed [FIELD_W-1:0] p_srsy, p_cysr, p_crsp, p_cpsr, p_cpcr;
  logic signed [FIELD_W-1:0] p_sp, p_sy, p_sr;

  assign m_load = !valid || !stall;
  assign p_load = !p_valid || m_load;
  assign t_load = !t_valid || p_load;
  assign load   = t_load;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      logic signed [CW:0]   xe, ye, sv, cv;
      logic signed [CW+1:0] sr, cr;
      xe = (CW+1)'(prev_lanes[l].x);
      ye = (CW+1)'(prev_lanes[l].y);
      unique case (prev_lanes[l].quad)
        2'd0: begin sv = ye;  cv = xe;  end
        2'd1: begin sv = xe;  cv = -ye; end
        2'd2: begin sv = -ye; cv = -xe; end
        default: begin sv = -xe; cv = ye; end
      endcase
      sr = ((CW+2)'(sv) + (CW+2)'(1 << (TRIG_SHIFT - 1))) >>> TRIG_SHIFT;
      cr = ((CW+2)'(cv) + (CW+2)'(1 << (TRIG_SHIFT - 1))) >>> TRIG_SHIFT;
      // rounded values sit well inside 17 bits before clamping
      trig_next[l].s = clamp17((FIELD_W+1)'(sr));
      trig_next[l].c = clamp17((FIELD_W+1)'(cr));
    end
  end

  always_comb begin
    logic signed [FIELD_W-1:0] sp, sy, sr;
    sp = p_sp;
    sy = p_sy;
    sr = p_sr;
    matrix_next.m00 = clamp17((FIELD_W+1)'(p_cpcy));
    matrix_next.m01 = clamp17(-(FIELD_W+1)'(p_cpsy));
    matrix_next.m02 = sp;
    matrix_next.m10 = clamp17((FIELD_W+1)'(mul_round(p_cysp, sr)) + (FIELD_W+1)'(p_crsy));
    matrix_next.m11 = clamp17((FIELD_W+1)'(p_crcy) - (FIELD_W+1)'(mul_round(p_spsr, sy)));
    matrix_next.m12 = clamp17(-(FIELD_W+1)'(p_cpsr));
    matrix_next.m20 = clamp17((FIELD_W+1)'(p_srsy) - (FIELD_W+1)'(mul_round(p_crcy, sp)));
    matrix_next.m21 = clamp17((FIELD_W+1)'(p_cysr) + (FIELD_W+1)'(mul_round(p_crsp, sy)));
    matrix_next.m22 = clamp17((FIELD_W+1)'(p_cpcr));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
      p_valid <= 1'b0;
      valid   <= 1'b0;
    end else begin
      if (t_load) t_valid <= prev_valid;
      if (p_load) p_valid <= t_valid;
      if (m_load) valid   <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (t_load) begin
      trig <= trig_next;
    end
    if (p_load) begin
      // trig[0] yaw, trig[1] pitch, trig[2] roll
      p_cpcy <= mul_round(trig[1].c, trig[0].c);
      p_cpsy <= mul_round(trig[1].c, trig[0].s);
      p_crsy <= mul_round(trig[2].c, trig[0].s);
      p_cysp <= mul_round(trig[0].c, trig[1].s);
      p_spsr <= mul_round(trig[1].s, trig[2].s);
      p_crcy <= mul_round(trig[2].c, trig[0].c);
      p_srsy <= mul_round(trig[2].s, trig[0].s);
      p_cysr <= mul_round(trig[0].c, trig[2].s);
      p_crsp <= mul_round(trig[2].c, trig[1].s);
      p_cpsr <= mul_round(trig[1].c, trig[2].s);
      p_cpcr <= mul_round(trig[1].c, trig[2].c);
      p_sp   <= trig[1].s;
      p_sy   <= trig[0].s;
      p_sr   <= trig[2].s;
    end
    if (m_load) begin
      matrix <= matrix_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/euler_zyx_to_rotation_matrix.sv */
// Top level: ZYX Euler angles to rotation matrix, chain of CORDIC cells then products.
// Between input and result lie the input slot, one slot per CORDIC cell, then stages T, P, M.
// Throughput: one transfer per cycle while the output is not stalled; every pipeline slot carries its own valid bit,
// so bubbles close up and an input is taken while a finished result waits.
// The chain of CORDIC cells, one iteration each, sets the depth.
// Synchronous reset empties every slot; no other state is kept.
`default_nettype none
module euler_zyx_to_rotation_matrix import ezr_pkg::*; #(
  parameter int TRIG_ITERATIONS = ezr_pkg::TRIG_ITERATIONS
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    angle_valid,
  output logic         angle_stall,
  input  wire angles_t angles,
  output logic         matrix_valid,
  input  wire logic    matrix_stall,
  output matrix_t      matrix
);

  logic       s0_valid, s0_load;
  ezr_lanes_t s0_lanes, s0_lanes_next;
  logic       cell_valid [TRIG_ITERATIONS+1];
  ezr_lanes_t cell_lanes [TRIG_ITERATIONS+1];
  logic       cell_load  [TRIG_ITERATIONS+1];

  function automatic ezr_lane_t lane_init(input logic [FIELD_W-1:0] a);
    ezr_lane_t r;
    logic [31:0] phase;
    phase  = 32'(a[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
    r.quad = phase[31:30];
    r.x    = CORDIC_GAIN;
    r.y    = '0;
    r.z    = CW'(phase[29:0]);
    return r;
  endfunction

  assign s0_lanes_next[0] = lane_init(angles.yaw_angle);
  assign s0_lanes_next[1] = lane_init(angles.pitch_angle);
  assign s0_lanes_next[2] = lane_init(angles.roll_angle);

  assign s0_load     = !s0_valid || cell_load[0];
  assign angle_stall = !s0_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_load) begin
      s0_valid <= angle_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_load) begin
      s0_lanes <= s0_lanes_next;
    end
  end

  assign cell_valid[0] = s0_valid;
  assign cell_lanes[0] = s0_lanes;

  for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_cell
    ezr_cordic_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .prev_valid(cell_valid[i]),
      .prev_lanes(cell_lanes[i]),
      .next_load (cell_load[i+1]),
      .load      (cell_load[i]),
      .valid     (cell_valid[i+1]),
      .lanes     (cell_lanes[i+1])
    );
  end

  ezr_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .prev_valid(cell_valid[TRIG_ITERATIONS]),
    .prev_lanes(cell_lanes[TRIG_ITERATIONS]),
    .stall     (matrix_stall),
    .load      (cell_load[TRIG_ITERATIONS]),
    .valid     (matrix_valid),
    .matrix    (matrix)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !matrix_valid)
    else $error("result valid straight after reset");
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
      angle_stall |-> (matrix_valid && matrix_stall))
    else $error("input stalled with the output free");
  a_free_flow: assert property (@(posedge clk) disable iff (rst)
      !matrix_stall |-> !angle_stall)
    else $error("input stalled while output drains");
  a_range: assert property (@(posedge clk) disable iff (rst)
      matrix_valid |-> (matrix.m10 <= ONE && matrix.m10 >= -ONE &&
                        matrix.m21 <= ONE && matrix.m21 >= -ONE))
    else $error("matrix entry beyond unity");

endmodule
`default_nettype wire

/* verif/euler_zyx_to_rotation_matrix_tb.sv */
// Testbench for the ZYX Euler angle to rotation matrix block: directed and random angles.
`timescale 1ns / 1ps
module euler_zyx_to_rotation_matrix_tb;
  import ezr_pkg::*;

  localparam int ONE_Q     = 1 << FRAC_BITS;
  localparam int PIPE_WAIT = TRIG_ITERATIONS + 40;
  localparam int STALL_MAX = 2000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    angle_valid = 1'b0;
  logic    angle_stall;
  angles_t angles = '0;
  logic    matrix_valid;
  logic    matrix_stall = 1'b0;
  matrix_t matrix;

  matrix_t expected_matrices[$];
  int      errors = 0;
  int      angles_sent = 0;
  int      matrices_seen = 0;
  int      quiet_cycles = 0;
  bit      sink_steady = 1'b0;
  bit      src_steady = 1'b0;

  euler_zyx_to_rotation_matrix dut (
    .clk(clk), .rst(rst),
    .angle_valid(angle_valid), .angle_stall(angle_stall), .angles(angles),
    .matrix_valid(matrix_valid), .matrix_stall(matrix_stall), .matrix(matrix)
  );

  always #6 clk = ~clk;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return asr(v + (longint'(1) << (s - 1)), s);
  endfunction

  function automatic longint sat_unit(longint v);
    if (v > ONE_Q) return ONE_Q;
    if (v < -ONE_Q) return -ONE_Q;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return rnd_shift(a * b, FRAC_BITS);
  endfunction

  function automatic longint turn_atan(int k);
    longint t[32] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
      64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
      64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005,
      64'h00000003, 64'h00000001, 64'h00000001, 64'h00000000};
    return t[k];
  endfunction

  function automatic void angle_trig(input logic [15:0] a, output longint s,
                                     output longint c);
    logic [31:0] phase;
    longint x, y, z, dx, dy, sv, cv;
    int k;
    phase = {a[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
    z = longint'(phase[29:0]);
    x = 652032874;
    y = 0;
    for (int i = 0; i < TRIG_ITERATIONS; i++) begin
      k = i % 32;
      dx = asr(y, k);
      dy = asr(x, k);
      if (z >= 0) begin
        x -= dx; y += dy; z -= turn_atan(k);
      end else begin
        x += dx; y -= dy; z += turn_atan(k);
      end
    end
    case (phase[31:30])
      2'd0: begin sv = y;  cv = x;  end
      2'd1: begin sv = x;  cv = -y; end
      2'd2: begin sv = -y; cv = -x; end
      default: begin sv = -x; cv = y; end
    endcase
    s = sat_unit(rnd_shift(sv, 30 - FRAC_BITS));
    c = sat_unit(rnd_shift(cv, 30 - FRAC_BITS));
  endfunction

  function automatic matrix_t rotation_of(angles_t a);
    longint sy, cy, sp, cp, sr, cr;
    matrix_t m;
    angle_trig(a.yaw_angle, sy, cy);
    angle_trig(a.pitch_angle, sp, cp);
    angle_trig(a.roll_angle, sr, cr);
    m.m00 = 16'(sat_unit(qmul(cp, cy)));
    m.m01 = 16'(sat_unit(-qmul(cp, sy)));
    m.m02 = 16'(sat_unit(sp));
    m.m10 = 16'(sat_unit(qmul(qmul(cy, sp), sr) + qmul(cr, sy)));
    m.m11 = 16'(sat_unit(qmul(cr, cy) - qmul(qmul(sp, sr), sy)));
    m.m12 = 16'(sat_unit(-qmul(cp, sr)));
    m.m20 = 16'(sat_unit(qmul(sr, sy) - qmul(qmul(cr, cy), sp)));
    m.m21 = 16'(sat_unit(qmul(cy, sr) + qmul(qmul(cr, sp), sy)));
    m.m22 = 16'(sat_unit(qmul(cp, cr)));
    return m;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  // one transfer; valid stays high across back-to-back items
  task automatic send_angles(logic [15:0] y, logic [15:0] p, logic [15:0] r);
    while (!src_steady && $urandom_range(99) < 16) begin
      angle_valid <= 1'b0;
      @(posedge clk);
    end
    angle_valid <= 1'b1;
    angles <= '{yaw_angle: y, pitch_angle: p, roll_angle: r};
    @(posedge clk);
    while (angle_stall) @(posedge clk);
    expected_matrices.insert(expected_matrices.size(), rotation_of(angles));
    angles_sent++;
  endtask

  task automatic go_idle();
    angle_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_extremes();
    logic [15:0] pts[10] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF,
                             16'h8001, 16'h0001, 16'hFFFF, 16'h2000, 16'h3FFF};
    for (int i = 0; i < 10; i++) send_angles(pts[i], pts[(i + 3) % 10], pts[(i + 7) % 10]);
    // pitch at +-pi/2 (gimbal lock), and all three angles at -pi
    send_angles(16'h1234, 16'h4000, 16'hABCD);
    send_angles(16'hABCD, 16'hC000, 16'h1234);
    send_angles(16'h8000, 16'h8000, 16'h8000);
    send_angles(16'h5555, 16'hAAAA, 16'hFFFF);
    go_idle();
  endtask

  task automatic test_random(int n);
    logic [15:0] y, p, r;
    for (int i = 0; i < n; i++) begin
      src_steady = (i >= n / 3) && (i < n / 2);
      sink_steady = src_steady;
      y = 16'($urandom);
      p = 16'($urandom);
      r = 16'($urandom);
      // bias some items onto quadrant boundaries
      if ($urandom_range(9) == 0) p = {$urandom_range(3) == 0 ? 2'b01 : 2'b11, 14'h0};
      if ($urandom_range(9) == 0) y = {2'($urandom), 14'h0};
      send_angles(y, p, r);
    end
    src_steady = 1'b0;
    sink_steady = 1'b0;
    go_idle();
  endtask

  always @(posedge clk) begin
    if (!rst) matrix_stall <= !sink_steady && ($urandom_range(99) < 16);
  end

  always @(posedge clk) begin
    matrix_t want;
    if (!rst && matrix_valid && !matrix_stall) begin
      matrices_seen++;
      if (expected_matrices.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = expected_matrices.pop_front();
        if (matrix.m00 !== want.m00) report_mismatch("m00", matrix.m00, want.m00);
        if (matrix.m01 !== want.m01) report_mismatch("m01", matrix.m01, want.m01);
        if (matrix.m02 !== want.m02) report_mismatch("m02", matrix.m02, want.m02);
        if (matrix.m10 !== want.m10) report_mismatch("m10", matrix.m10, want.m10);
        if (matrix.m11 !== want.m11) report_mismatch("m11", matrix.m11, want.m11);
        if (matrix.m12 !== want.m12) report_mismatch("m12", matrix.m12, want.m12);
        if (matrix.m20 !== want.m20) report_mismatch("m20", matrix.m20, want.m20);
        if (matrix.m21 !== want.m21) report_mismatch("m21", matrix.m21, want.m21);
        if (matrix.m22 !== want.m22) report_mismatch("m22", matrix.m22, want.m22);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (angle_valid && !angle_stall) || (matrix_valid && !matrix_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_MAX) begin
        $display("euler_zyx_to_rotation_matrix_tb failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_random(1800);
    while (expected_matrices.size() != 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
    $display("sent %0d angle triples, checked %0d matrices", angles_sent, matrices_seen);
    $display("covered quadrant edges, +-pi, gimbal lock and random angles with stalls");
    if (errors == 0) begin
      $display("euler_zyx_to_rotation_matrix_tb passed");
    end else begin
      $display("euler_zyx_to_rotation_matrix_tb failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/ezr_pkg.sv
rtl/core/ezr_cordic_cell.sv
rtl/core/ezr_matrix.sv
rtl/core/euler_zyx_to_rotation_matrix.sv
verif/euler_zyx_to_rotation_matrix_tb.sv
